[hw/rtl/cfd_pkg.sv]
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the control frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_SKIP  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] command;
        logic [15:0] word_count;
        logic [15:0] data_word;
        logic [15:0] word_index;
        logic        last;
    } cfd_result_t;

endpackage

[hw/rtl/control_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// control_frame_deframer_unit
// Deframer for a byte-serial control link with sync, header and data words.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready, s_rx_byte) takes one received byte per
// beat. The block hunts for two 0x55 sync bytes, gathers a four-byte header
// (command, then word count, both big-endian) and then assembles that many
// big-endian 16-bit data words. The result channel (m_*) carries one beat per
// data word, one beat for a frame that announces zero words, and one beat for
// each non-sync byte seen during the hunt. Sync, header and high data bytes
// give no result beat.
// A byte waits in an input register, and its result is loaded into the result
// register when the byte moves on; the result is shown from that register until
// the receiver takes it.
// One byte is taken every cycle while the receiver keeps m_ready high; the
// rate is set by the single framing state update per byte.
// When the receiver stalls, the held result stays stable and bytes that give
// no result still pass through; a byte that gives a result waits in the input
// register, and s_ready drops once that register is also occupied.
// Synchronous reset (aresetn low) empties both registers and returns the
// framer to the sync hunt with all counters cleared.
// ----------------------------------------------------------------------------
module control_frame_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_command,
    output logic [15:0] m_word_count,
    output logic [15:0] m_data_word,
    output logic [15:0] m_word_index,
    output logic        m_last
);
    import cfd_pkg::*;

    logic        in_valid;
    logic [7:0]  in_byte;
    logic        advance;
    logic        has_result;
    cfd_result_t core_result;
    cfd_result_t out_result;

    // A byte moves on when it gives no result beat or when the result
    // register is free or is being emptied in this cycle.
    assign advance = in_valid && (!has_result || !m_valid || m_ready);

    cfd_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    cfd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_byte    (in_byte),
        .has_result (has_result),
        .result     (core_result)
    );

    cfd_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && has_result),
        .load_result (core_result),
        .m_ready     (m_ready),
        .out_valid   (m_valid),
        .out_result  (out_result)
    );

    assign m_kind       = out_result.kind;
    assign m_command    = out_result.command;
    assign m_word_count = out_result.word_count;
    assign m_data_word  = out_result.data_word;
    assign m_word_index = out_result.word_index;
    assign m_last       = out_result.last;

endmodule

[hw/rtl/cfd_in_stage.sv]
// ----------------------------------------------------------------------------
// cfd_in_stage
// Input register that holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module cfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The stage frees up in the same cycle that its byte moves on.
    assign s_ready    = !valid_reg || advance;
    assign in_valid   = valid_reg;
    assign in_byte    = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

[hw/rtl/cfd_core.sv]
// ----------------------------------------------------------------------------
// cfd_core
// Framing state and the single-pass logic that turns one byte into a result.
// ----------------------------------------------------------------------------
module cfd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           in_byte,
    output logic                 has_result,
    output cfd_pkg::cfd_result_t result
);
    import cfd_pkg::*;

    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]  phase_reg,        phase_next;
    logic        sync_seen_reg,    sync_seen_next;
    logic [1:0]  header_pos_reg,   header_pos_next;
    logic [31:0] header_shift_reg, header_shift_next;
    logic [15:0] words_done_reg,   words_done_next;
    logic [7:0]  high_byte_reg,    high_byte_next;
    logic        low_pending_reg,  low_pending_next;

    logic [16:0] idx_plus_one;
    logic        is_last;

    assign idx_plus_one = {1'b0, words_done_reg} + 17'd1;
    assign is_last      = idx_plus_one >= {1'b0, header_shift_reg[15:0]};

    always_comb begin
        phase_next        = phase_reg;
        sync_seen_next    = sync_seen_reg;
        header_pos_next   = header_pos_reg;
        header_shift_next = header_shift_reg;
        words_done_next   = words_done_reg;
        high_byte_next    = high_byte_reg;
        low_pending_next  = low_pending_reg;
        has_result        = 1'b0;
        result            = '0;

        unique case (phase_reg)
            PH_HEAD: begin
                header_shift_next = {header_shift_reg[23:0], in_byte};
                header_pos_next   = header_pos_reg + 2'd1;
                if (header_pos_reg == 2'd3) begin
                    words_done_next  = '0;
                    low_pending_next = 1'b0;
                    if (header_shift_next[15:0] == 16'd0) begin
                        has_result     = 1'b1;
                        result.kind    = KIND_EMPTY;
                        result.command = header_shift_next[31:16];
                        result.last    = 1'b1;
                        phase_next     = PH_SYNC;
                        sync_seen_next = 1'b0;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (!low_pending_reg) begin
                    high_byte_next   = in_byte;
                    low_pending_next = 1'b1;
                end else begin
                    low_pending_next  = 1'b0;
                    has_result        = 1'b1;
                    result.kind       = KIND_DATA;
                    result.command    = header_shift_reg[31:16];
                    result.word_count = header_shift_reg[15:0];
                    result.data_word  = {high_byte_reg, in_byte};
                    result.word_index = words_done_reg;
                    result.last       = is_last;
                    words_done_next   = idx_plus_one[15:0];
                    if (is_last) begin
                        phase_next      = PH_SYNC;
                        sync_seen_next  = 1'b0;
                        header_pos_next = 2'd0;
                        words_done_next = '0;
                    end
                end
            end
            default: begin
                // Sync hunt; the unused phase code behaves the same way.
                phase_next = PH_SYNC;
                if (in_byte == SYNC_BYTE) begin
                    if (sync_seen_reg) begin
                        sync_seen_next  = 1'b0;
                        phase_next      = PH_HEAD;
                        header_pos_next = 2'd0;
                    end else begin
                        sync_seen_next = 1'b1;
                    end
                end else begin
                    has_result       = 1'b1;
                    result.kind      = KIND_SKIP;
                    result.data_word = {8'd0, in_byte};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SYNC;
            sync_seen_reg    <= 1'b0;
            header_pos_reg   <= 2'd0;
            header_shift_reg <= '0;
            words_done_reg   <= '0;
            high_byte_reg    <= '0;
            low_pending_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            sync_seen_reg    <= sync_seen_next;
            header_pos_reg   <= header_pos_next;
            header_shift_reg <= header_shift_next;
            words_done_reg   <= words_done_next;
            high_byte_reg    <= high_byte_next;
            low_pending_reg  <= low_pending_next;
        end
    end

endmodule

[hw/rtl/cfd_out_stage.sv]
// ----------------------------------------------------------------------------
// cfd_out_stage
// Result register that holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cfd_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  cfd_pkg::cfd_result_t load_result,
    input  logic                 m_ready,
    output logic                 out_valid,
    output cfd_pkg::cfd_result_t out_result
);
    import cfd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    cfd_result_t result_reg;

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

endmodule

[hw/rtl/cfd_checker.sv]
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the result beats of the control frame deframer.
// ----------------------------------------------------------------------------
module cfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_rx_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [15:0] m_command,
    input logic [15:0] m_word_count,
    input logic [15:0] m_data_word,
    input logic [15:0] m_word_index,
    input logic        m_last
);
    import cfd_pkg::*;

    // An offered byte that is not taken stays offered and unchanged.
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("input beat changed while waiting");

    // A stalled result beat holds still.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_word) && $stable(m_kind)
            && $stable(m_word_index) && $stable(m_last))
        else $error("result beat changed while stalled");

    // A skipped byte carries nothing but the byte itself.
    a_skip_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_SKIP |-> m_command == 16'd0 && m_word_count == 16'd0
            && m_word_index == 16'd0 && !m_last && m_data_word[15:8] == 8'd0)
        else $error("skipped-byte beat has stray fields");

    // An empty frame ends the frame and has no word.
    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_EMPTY |-> m_last && m_word_count == 16'd0
            && m_data_word == 16'd0 && m_word_index == 16'd0)
        else $error("empty-frame beat malformed");

    // The last mark of a data word follows from its index and the count.
    a_data_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DATA |->
            m_last == (({1'b0, m_word_index} + 17'd1) >= {1'b0, m_word_count}))
        else $error("data beat last mark disagrees with index and count");

endmodule

bind control_frame_deframer_unit cfd_checker u_cfd_checker (.*);

[test/control_frame_deframer_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// control_frame_deframer_unit_test
// Self-checking bench for the control frame deframer: a byte stream of sync
// bytes, headers, data words and line noise goes in, and every result beat is
// checked against a cycle-free model of the framing state machine.
// ----------------------------------------------------------------------------
module control_frame_deframer_unit_test;

    import cfd_pkg::*;

    localparam int unsigned CLOCK_HALF   = 6;
    localparam int unsigned RESET_CYCLES = 3;
    localparam int unsigned STREAM_BYTES = 1500;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 150;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // ------------------------------------------------------------------------
    // Scoreboard. It carries its own copy of the framer state, works out what
    // each accepted byte should produce, and holds those results in order
    // until the block shows them.
    // ------------------------------------------------------------------------
    class frame_scoreboard;

        typedef enum logic [1:0] {
            HUNT    = 2'd0,
            HEADER  = 2'd1,
            PAYLOAD = 2'd2
        } framer_phase_e;

        framer_phase_e phase;
        logic [1:0]    sync_count;
        logic [1:0]    header_count;
        logic [31:0]   header_bits;
        logic [15:0]   words_sent;
        logic [7:0]    held_high;
        logic          half_word;
        cfd_result_t   expected_q[$];
        int unsigned   errors;

        function new();
            header_bits = '0;
            held_high   = '0;
            errors      = 0;
            return_to_hunt();
        endfunction

        function void return_to_hunt();
            phase        = HUNT;
            sync_count   = '0;
            header_count = '0;
            words_sent   = '0;
            half_word    = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] rx);
            cfd_result_t res;
            logic [15:0] frame_cmd;
            logic [15:0] frame_len;

            // The command and count of the frame in progress, as held before
            // this byte is taken in.
            frame_cmd = header_bits[31:16];
            frame_len = header_bits[15:0];
            res       = '0;

            case (phase)
                HEADER: begin
                    header_bits  = {header_bits[23:0], rx};
                    header_count = header_count + 2'd1;
                    if (header_count == 2'd0) begin
                        if (header_bits[15:0] == 16'd0) begin
                            res.kind    = KIND_EMPTY;
                            res.command = header_bits[31:16];
                            res.last    = 1'b1;
                            expected_q.push_back(res);
                            return_to_hunt();
                        end else begin
                            phase      = PAYLOAD;
                            words_sent = '0;
                            half_word  = 1'b0;
                        end
                    end
                end
                PAYLOAD: begin
                    if (!half_word) begin
                        held_high = rx;
                        half_word = 1'b1;
                    end else begin
                        half_word      = 1'b0;
                        res.kind       = KIND_DATA;
                        res.command    = frame_cmd;
                        res.word_count = frame_len;
                        res.data_word  = {held_high, rx};
                        res.word_index = words_sent;
                        res.last       = ({1'b0, words_sent} + 17'd1) >= {1'b0, frame_len};
                        expected_q.push_back(res);
                        words_sent = words_sent + 16'd1;
                        if (res.last) begin
                            return_to_hunt();
                        end
                    end
                end
                default: begin
                    phase = HUNT;
                    if (rx == SYNC_BYTE) begin
                        sync_count = sync_count + 2'd1;
                        if (sync_count >= 2'd2) begin
                            sync_count   = '0;
                            phase        = HEADER;
                            header_count = '0;
                        end
                    end else begin
                        res.kind      = KIND_SKIP;
                        res.data_word = {8'h00, rx};
                        expected_q.push_back(res);
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(cfd_result_t got);
            cfd_result_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: kind %0d data 0x%0h",
                       got.kind, got.data_word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind",       want.kind,       got.kind);
            compare_field("command",    want.command,    got.command);
            compare_field("word_count", want.word_count, got.word_count);
            compare_field("data_word",  want.data_word,  got.data_word);
            compare_field("word_index", want.word_index, got.word_index);
            compare_field("last",       want.last,       got.last);
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Block under test. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_command;
    logic [15:0] m_word_count;
    logic [15:0] m_data_word;
    logic [15:0] m_word_index;
    logic        m_last;

    control_frame_deframer_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_command    (m_command),
        .m_word_count (m_word_count),
        .m_data_word  (m_data_word),
        .m_word_index (m_word_index),
        .m_last       (m_last)
    );

    always #(CLOCK_HALF) aclk = ~aclk;

    frame_scoreboard sb;
    logic [7:0]      byte_stream[$];
    int unsigned     burst_left   = 0;
    int unsigned     results_seen = 0;
    int unsigned     cycle_count  = 0;

    // The opening bytes cover the corner cases one at a time: skipped bytes at
    // both extremes, a stray byte between the two sync bytes that must not
    // clear the sync count, an empty frame with an all-ones command, a single
    // word frame with an all-zero command, and a two word frame.
    logic [7:0] opening_bytes [27] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55, 8'hFF, 8'hFF, 8'h00, 8'h00,
        8'h55, 8'h55, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00,
        8'h55, 8'h55, 8'h12, 8'h34, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h80, 8'h01
    };

    // Any byte except the sync pattern. Keeping stray sync bytes out of the
    // noise stops the framer from locking onto a header with a huge count.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == SYNC_BYTE) ? 8'h54 : b;
    endfunction

    // Queues one complete frame. Non-sync bytes may be slipped in between the
    // two sync bytes, since the hunt does not clear its count on them. A
    // command whose high byte is the sync pattern gives three sync bytes in a
    // row, where the third must be taken as header.
    task automatic add_frame(input logic [15:0] cmd, input logic [15:0] len,
                             input int unsigned stray);
        byte_stream.push_back(SYNC_BYTE);
        repeat (stray) byte_stream.push_back(noise_byte());
        byte_stream.push_back(SYNC_BYTE);
        byte_stream.push_back(cmd[15:8]);
        byte_stream.push_back(cmd[7:0]);
        byte_stream.push_back(len[15:8]);
        byte_stream.push_back(len[7:0]);
        repeat (2 * len) begin
            // Data bytes may be anything, the sync pattern included.
            if ($urandom_range(0, 9) == 0) begin
                byte_stream.push_back(SYNC_BYTE);
            end else begin
                byte_stream.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Offers one byte and waits for its beat. The sender runs in bursts; at
    // the start of each burst it may drop valid for a random gap. Now and then
    // a burst is long, giving a stretch with no idle cycles at all.
    task automatic send_byte(input logic [7:0] rx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(rx);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset once, build the byte stream, send it, then drain.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned pick;
        logic [15:0] len;

        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_bytes[i]) byte_stream.push_back(opening_bytes[i]);

        // Random part. Most of it is well-formed frames with random content,
        // mostly short, now and then a few hundred words long. The rest is
        // noise between frames and sync sequences broken by stray bytes.
        while (byte_stream.size() < STREAM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                len = 16'd0;
            end else if (pick < 85) begin
                len = 16'($urandom_range(1, 6));
            end else if (pick < 98) begin
                len = 16'($urandom_range(7, 40));
            end else begin
                len = 16'($urandom_range(100, 300));
            end

            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                add_frame(16'($urandom_range(0, 65535)), len, 0);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) byte_stream.push_back(noise_byte());
            end else if (pick < 88) begin
                add_frame(16'($urandom_range(0, 65535)), len, $urandom_range(1, 3));
            end else begin
                add_frame({SYNC_BYTE, 8'($urandom_range(0, 255))}, len, 0);
            end
        end

        foreach (byte_stream[i]) send_byte(byte_stream[i]);
        s_valid <= 1'b0;

        // Every byte has been taken. Wait for the results still owed, then a
        // few more cycles so that a spurious extra beat would be caught.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("control_frame_deframer_unit_test: done, clean");
        end else begin
            $display("control_frame_deframer_unit_test: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. It switches between modes of its own: always ready, mostly
    // ready and mostly stalled. Once enough results have come it holds off
    // for a long stretch so the block fills up and must stall its input.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        bit          held;

        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
            @(posedge aclk);
        end
    end

    // Result monitor. Values are read as they stood just before the edge, so
    // a beat is exactly the cycle in which both valid and ready were high.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_kind, m_command, m_word_count, m_data_word,
                             m_word_index, m_last});
            results_seen++;
        end
    end

    // Watchdog. The limit is many times the slowest correct run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("control_frame_deframer_unit_test: done, errors");
            $finish;
        end
    end

endmodule
